@@ design/mlr_pkg.sv @@
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types, constants, region table and microcode for the midpoint line
// rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  localparam int COORD_W     = 6;   // world coordinate width
  localparam int WALK_W      = 7;   // octant-space coordinate width
  localparam int DEC_W       = 9;   // decision variable width
  localparam int REGION_W    = 4;
  localparam int COORD_LIMIT = 31;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [WALK_W-1:0]  walk_t;
  typedef logic signed [DEC_W-1:0]   dec_t;
  typedef logic [REGION_W-1:0]       region_t;
  typedef logic [1:0]                step_t;

  // Region number by [swap][negate x][negate y].
  localparam region_t REGION_TABLE [2][2][2] = '{
    '{'{4'd1, 4'd8}, '{4'd4, 4'd5}},
    '{'{4'd2, 4'd3}, '{4'd7, 4'd6}}
  };

  // octant_flags bit positions
  localparam int FLAG_SWAP = 0;
  localparam int FLAG_NEGX = 1;
  localparam int FLAG_NEGY = 2;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_IN_ACC,
    COND_EMPTY,
    COND_LAST,
    COND_ALWAYS
  } cond_t;

  // Program step addresses
  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_SETUP = 2'd1;
  localparam step_t STEP_WALK  = 2'd2;
  localparam step_t STEP_EMPTY = 2'd3;

  typedef struct packed {
    logic  in_ready;
    logic  setup;
    logic  emit;
    logic  emit_empty;
    logic  advance;     // fall through to the next step when no jump
    cond_t cond;
    step_t target;
  } uword_t;

  // Datapath controls issued by the sequencer
  typedef struct packed {
    logic load_in;
    logic setup;
    logic walk;
    logic load_empty;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } status_t;

  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    w = '0;
    unique case (pc)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_IN_ACC;
        w.target   = STEP_SETUP;
      end
      STEP_SETUP: begin
        w.setup   = 1'b1;
        w.advance = 1'b1;
        w.cond    = COND_EMPTY;
        w.target  = STEP_EMPTY;
      end
      STEP_WALK: begin
        w.emit   = 1'b1;
        w.cond   = COND_LAST;
        w.target = STEP_IDLE;
      end
      STEP_EMPTY: begin
        w.emit_empty = 1'b1;
        w.cond       = COND_ALWAYS;
        w.target     = STEP_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Clamp a raw coordinate to -COORD_LIMIT..COORD_LIMIT
  function automatic coord_t sat_coord(input coord_t v);
    coord_t r;
    r = v;
    if (int'(v) > COORD_LIMIT) r = COORD_W'(COORD_LIMIT);
    if (int'(v) < -COORD_LIMIT) r = COORD_W'(-COORD_LIMIT);
    return r;
  endfunction

endpackage

@@ design/mlr_sequencer.sv @@
// ----------------------------------------------------------------------------
// mlr_sequencer
// Step counter over the microcode table with conditional jumps; turns the
// current control word into datapath strobes.
// ----------------------------------------------------------------------------
module mlr_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mlr_pkg::status_t sts,
  output mlr_pkg::ctrl_t   ctrl,
  output logic            busy
);
  import mlr_pkg::*;

  step_t  pc_r, pc_nxt;
  uword_t uw;
  logic   stall;
  logic   cond_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    uw    = ucode_rom(pc_r);
    stall = (uw.emit || uw.emit_empty) && !sts.out_free;
    unique case (uw.cond)
      COND_NEVER:  cond_hit = 1'b0;
      COND_IN_ACC: cond_hit = in_valid;
      COND_EMPTY:  cond_hit = sts.empty;
      COND_LAST:   cond_hit = sts.last;
      COND_ALWAYS: cond_hit = 1'b1;
      default:     cond_hit = 1'b0;
    endcase
    priority if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = uw.target;
    end else if (uw.advance) begin
      pc_nxt = pc_r + 2'd1;
    end else begin
      pc_nxt = pc_r;
    end

    in_ready        = uw.in_ready;
    ctrl.load_in    = uw.in_ready && in_valid;
    ctrl.setup      = uw.setup;
    ctrl.walk       = uw.emit && sts.out_free;
    ctrl.load_empty = uw.emit_empty && sts.out_free;
  end

  assign busy = (pc_r != STEP_IDLE);

endmodule

@@ design/mlr_datapath.sv @@
// ----------------------------------------------------------------------------
// mlr_datapath
// Coordinate registers, octant classification, midpoint decision update and
// the result register.
// ----------------------------------------------------------------------------
module mlr_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  mlr_pkg::ctrl_t   ctrl,
  output mlr_pkg::status_t sts,
  input  mlr_pkg::coord_t  in_start_x,
  input  mlr_pkg::coord_t  in_start_y,
  input  mlr_pkg::coord_t  in_end_x,
  input  mlr_pkg::coord_t  in_end_y,
  output logic             out_valid,
  input  logic             out_ready,
  output mlr_pkg::coord_t  out_pixel_x,
  output mlr_pkg::coord_t  out_pixel_y,
  output logic             out_step_ne,
  output mlr_pkg::region_t out_region,
  output logic             out_empty_line,
  output logic             out_last_pixel
);
  import mlr_pkg::*;

  coord_t  sx_r, sy_r, ex_r, ey_r;
  walk_t   walk_x_r, walk_y_r, walk_end_x_r;
  walk_t   major_delta_r, minor_delta_r;
  dec_t    decision_value_r;
  logic [2:0] octant_flags_r;
  region_t region_r;

  // setup
  walk_t dx, dy, adx, ady, mj, mn;
  walk_t ax, ay, bx, by, tdx, tdy;
  logic  swp, fx, fy;
  dec_t  d0;

  // walk
  logic  ne;
  walk_t xn, yn, wx, wy, px, py;
  dec_t  dn;

  logic  out_valid_r;
  coord_t px_r, py_r;
  logic  ne_r, empty_r, last_r;
  region_t oreg_r;

  always_comb begin
    dx  = walk_t'(ex_r) - walk_t'(sx_r);
    dy  = walk_t'(ey_r) - walk_t'(sy_r);
    adx = dx[WALK_W-1] ? -dx : dx;
    ady = dy[WALK_W-1] ? -dy : dy;
    swp = $unsigned(ady) > $unsigned(adx);
    mj  = swp ? dy : dx;
    mn  = swp ? dx : dy;
    fx  = mj[WALK_W-1];
    fy  = mn[WALK_W-1];
    ax  = swp ? walk_t'(sy_r) : walk_t'(sx_r);
    ay  = swp ? walk_t'(sx_r) : walk_t'(sy_r);
    bx  = swp ? walk_t'(ey_r) : walk_t'(ex_r);
    by  = swp ? walk_t'(ex_r) : walk_t'(ey_r);
    if (fx) begin
      ax = -ax;
      bx = -bx;
    end
    if (fy) begin
      ay = -ay;
      by = -by;
    end
    tdx = bx - ax;
    tdy = by - ay;
    d0  = {tdy[WALK_W-1], tdy, 1'b0} - dec_t'(tdx);
  end

  always_comb begin
    ne = !decision_value_r[DEC_W-1];
    xn = walk_x_r + walk_t'(1);
    yn = walk_y_r + walk_t'(ne);
    if (ne) begin
      dn = decision_value_r
         + {minor_delta_r[WALK_W-1], minor_delta_r, 1'b0}
         - {major_delta_r[WALK_W-1], major_delta_r, 1'b0};
    end else begin
      dn = decision_value_r + {minor_delta_r[WALK_W-1], minor_delta_r, 1'b0};
    end
    wx = octant_flags_r[FLAG_NEGX] ? -xn : xn;
    wy = octant_flags_r[FLAG_NEGY] ? -yn : yn;
    px = octant_flags_r[FLAG_SWAP] ? wy : wx;
    py = octant_flags_r[FLAG_SWAP] ? wx : wy;
  end

  assign sts.empty    = (dx == '0) && (dy == '0);
  assign sts.last     = (xn == walk_end_x_r);
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      sx_r <= sat_coord(in_start_x);
      sy_r <= sat_coord(in_start_y);
      ex_r <= sat_coord(in_end_x);
      ey_r <= sat_coord(in_end_y);
    end
    if (ctrl.setup) begin
      walk_x_r         <= ax;
      walk_y_r         <= ay;
      walk_end_x_r     <= bx;
      major_delta_r    <= tdx;
      minor_delta_r    <= tdy;
      decision_value_r <= d0;
      octant_flags_r   <= {fy, fx, swp};
      region_r         <= REGION_TABLE[swp][fx][fy];
    end
    if (ctrl.walk) begin
      walk_x_r         <= xn;
      walk_y_r         <= yn;
      decision_value_r <= dn;
      px_r    <= px[COORD_W-1:0];
      py_r    <= py[COORD_W-1:0];
      ne_r    <= ne;
      oreg_r  <= region_r;
      empty_r <= 1'b0;
      last_r  <= sts.last;
    end
    if (ctrl.load_empty) begin
      px_r    <= sx_r;
      py_r    <= sy_r;
      ne_r    <= 1'b0;
      oreg_r  <= '0;
      empty_r <= 1'b1;
      last_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.walk || ctrl.load_empty) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = px_r;
  assign out_pixel_y    = py_r;
  assign out_step_ne    = ne_r;
  assign out_region     = oreg_r;
  assign out_empty_line = empty_r;
  assign out_last_pixel = last_r;

endmodule

@@ design/midpoint_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_core
// All-octant midpoint line rasterizer: one line request in, one item per
// pixel out, driven by a four-step microcode sequencer.
//
//   channel | direction | payload
//   in_     | input     | start_x, start_y, end_x, end_y (signed 6 bit)
//   out_    | output    | pixel_x, pixel_y, step_ne, region, empty_line,
//           |           | last_pixel
//
// A line passes an accept step and a setup step, then the walk step emits
// one pixel per cycle while the result register is free; an empty line goes
// to the empty step instead. The walk step emits at most one pixel per cycle
// into the result register. Reset returns the sequencer to the idle step and
// clears the result valid. A stalled result register holds the walk step.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mlr_pkg::coord_t  in_start_x,
  input  mlr_pkg::coord_t  in_start_y,
  input  mlr_pkg::coord_t  in_end_x,
  input  mlr_pkg::coord_t  in_end_y,
  output logic             out_valid,
  input  logic             out_ready,
  output mlr_pkg::coord_t  out_pixel_x,
  output mlr_pkg::coord_t  out_pixel_y,
  output logic             out_step_ne,
  output mlr_pkg::region_t out_region,
  output logic             out_empty_line,
  output logic             out_last_pixel
);
  import mlr_pkg::*;

  ctrl_t   ctrl;
  status_t sts;
  logic    busy;

  mlr_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctrl     (ctrl),
    .busy     (busy)
  );

  mlr_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .sts            (sts),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_step_ne    (out_step_ne),
    .out_region     (out_region),
    .out_empty_line (out_empty_line),
    .out_last_pixel (out_last_pixel)
  );

  // An accepted item moves the sequencer off the idle step
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (busy && !in_ready))
    else $error("sequencer did not leave idle after accepting an item");

  // Never ready while a line is in flight
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_ready)
    else $error("input ready while busy");

  // Empty line result carries region zero and closes the line
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_line) |-> (out_last_pixel && out_region == '0))
    else $error("malformed empty-line result");

  // Drawn pixels always carry a real region
  a_region_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_empty_line) |-> (out_region != '0 && !out_region[3]
      || out_region == 4'd8))
    else $error("pixel with invalid region");

endmodule

@@ dv/tb_midpoint_line_rasterizer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer_core
// Self-checking bench for the all-octant midpoint line rasterizer. Line
// requests go in through a bursty sender, and pixels come out against a
// receiver that stalls on its own schedule. A behavioral rasterizer works out
// the pixel stream of each accepted line, and every pixel that comes out is
// checked field by field against the oldest pending one.
// ----------------------------------------------------------------------------
module tb_midpoint_line_rasterizer_core;
  import mlr_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_LINES = 200;
  localparam int CLAMP        = COORD_LIMIT;

  // Region number by [swap][negate x][negate y]
  localparam int REGION_OF [2][2][2] = '{
    '{'{1, 8}, '{4, 5}},
    '{'{2, 3}, '{7, 6}}
  };

  typedef enum int {LINE_ANY, LINE_SHORT, LINE_AXIS, LINE_DIAG, LINE_EMPTY,
                    LINE_CORNER} line_kind_e;
  typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY}
    ready_mode_e;

  typedef struct {
    coord_t  x;
    coord_t  y;
    logic    ne;
    region_t region;
    logic    empty;
    logic    last;
  } pixel_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  coord_t  in_start_x;
  coord_t  in_start_y;
  coord_t  in_end_x;
  coord_t  in_end_y;
  logic    out_valid;
  logic    out_ready = 1'b0;
  coord_t  out_pixel_x;
  coord_t  out_pixel_y;
  logic    out_step_ne;
  region_t out_region;
  logic    out_empty_line;
  logic    out_last_pixel;

  pixel_t      pending_pixels[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          stall_left = 0;

  midpoint_line_rasterizer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_step_ne    (out_step_ne),
    .out_region     (out_region),
    .out_empty_line (out_empty_line),
    .out_last_pixel (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_coord(input coord_t raw);
    int v;
    v = int'(raw);
    if (v > CLAMP) v = CLAMP;
    if (v < -CLAMP) v = -CLAMP;
    return v;
  endfunction

  function automatic void predict_line(input coord_t sx_in, input coord_t sy_in,
                                       input coord_t ex_in, input coord_t ey_in);
    int     sx, sy, ex, ey, dx, dy, adx, ady;
    int     ax, ay, bx, by, tdx, tdy, d, x, y, wx, wy;
    bit     swp, fx, fy;
    pixel_t p;
    sx = clamp_coord(sx_in);
    sy = clamp_coord(sy_in);
    ex = clamp_coord(ex_in);
    ey = clamp_coord(ey_in);
    dx = ex - sx;
    dy = ey - sy;
    if (dx == 0 && dy == 0) begin
      p.x      = coord_t'(sx);
      p.y      = coord_t'(sy);
      p.ne     = 1'b0;
      p.region = '0;
      p.empty  = 1'b1;
      p.last   = 1'b1;
      pending_pixels.insert(pending_pixels.size(), p);
      return;
    end
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    // x stays major on a tie
    swp = ady > adx;
    fx  = ((swp ? dy : dx) < 0);
    fy  = ((swp ? dx : dy) < 0);
    ax = swp ? sy : sx;
    ay = swp ? sx : sy;
    bx = swp ? ey : ex;
    by = swp ? ex : ey;
    if (fx) begin
      ax = -ax;
      bx = -bx;
    end
    if (fy) begin
      ay = -ay;
      by = -by;
    end
    tdx = bx - ax;
    tdy = by - ay;
    y = ay;
    d = 2 * tdy - tdx;
    for (x = ax + 1; x <= bx; x++) begin
      // a zero decision takes the NE step
      if (d < 0) begin
        d += 2 * tdy;
        p.ne = 1'b0;
      end else begin
        y++;
        d += 2 * (tdy - tdx);
        p.ne = 1'b1;
      end
      wx = fx ? -x : x;
      wy = fy ? -y : y;
      p.x      = coord_t'(swp ? wy : wx);
      p.y      = coord_t'(swp ? wx : wy);
      p.region = region_t'(REGION_OF[swp][fx][fy]);
      p.empty  = 1'b0;
      p.last   = (x == bx);
      pending_pixels.insert(pending_pixels.size(), p);
    end
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel item x=%0d y=%0d", out_pixel_x, out_pixel_y);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", int'(want.x), int'(out_pixel_x));
        check_field("pixel_y", int'(want.y), int'(out_pixel_y));
        check_field("step_ne", int'(want.ne), int'(out_step_ne));
        check_field("region", int'(want.region), int'(out_region));
        check_field("empty_line", int'(want.empty), int'(out_empty_line));
        check_field("last_pixel", int'(want.last), int'(out_last_pixel));
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (stall_left != 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // ------------------------------------------------------------------- sender

  // Enter and leave at a falling edge; keep valid high inside a burst.
  task automatic send_line(input int sx, input int sy,
                           input int ex, input int ey);
    in_valid   <= 1'b1;
    in_start_x <= coord_t'(sx);
    in_start_y <= coord_t'(sy);
    in_end_x   <= coord_t'(ex);
    in_end_y   <= coord_t'(ey);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_line(coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey));
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 6);
    end
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom_range(0, 63));
  endfunction

  function automatic coord_t corner_coord();
    case ($urandom_range(0, 3))
      0:       return coord_t'(-32);
      1:       return coord_t'(-CLAMP);
      2:       return coord_t'(CLAMP);
      default: return '0;
    endcase
  endfunction

  // Offset a coordinate, pinned to the 6-bit range
  function automatic coord_t near_coord(input coord_t base, input int delta);
    int v;
    v = int'(base) + delta;
    if (v > 31) v = 31;
    if (v < -32) v = -32;
    return coord_t'(v);
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_extremes();
    send_line(-32, -32, 31, 31);
    send_line(31, -32, -32, 31);
    send_line(-31, 0, 31, 0);
    send_line(0, 31, 0, -32);
    send_line(-32, 31, 31, -32);
    send_line(0, 0, 1, 0);
    send_line(0, 0, 0, -1);
  endtask

  task automatic test_empty_lines();
    send_line(5, -5, 5, -5);
    // -32 saturates onto -31, so this collapses to a point
    send_line(-32, -32, -31, -31);
    send_line(31, 31, 31, 31);
  endtask

  task automatic test_octants();
    send_line(0, 0, 10, 3);
    send_line(0, 0, 3, 10);
    send_line(0, 0, -3, 10);
    send_line(0, 0, -10, 3);
    send_line(0, 0, -10, -3);
    send_line(0, 0, -3, -10);
    send_line(0, 0, 3, -10);
    send_line(0, 0, 10, -3);
  endtask

  task automatic test_ties();
    send_line(0, 0, 7, 7);
    send_line(2, 1, -5, 8);
    send_line(-1, -1, -8, -8);
    send_line(3, -3, 10, -10);
    // zero decision at the first step
    send_line(0, 0, 4, 2);
  endtask

  task automatic test_random();
    line_kind_e kind;
    coord_t     sx, sy, ex, ey;
    int         len;
    for (int i = 0; i < RANDOM_LINES; i++) begin
      len  = $urandom_range(0, 8);
      kind = (len > 5) ? LINE_ANY : line_kind_e'(len);
      sx = any_coord();
      sy = any_coord();
      ex = any_coord();
      ey = any_coord();
      case (kind)
        LINE_SHORT: begin
          ex = near_coord(sx, $urandom_range(0, 8) - 4);
          ey = near_coord(sy, $urandom_range(0, 8) - 4);
        end
        LINE_AXIS: begin
          if ($urandom_range(0, 1)) ex = sx;
          else ey = sy;
        end
        LINE_DIAG: begin
          len = $urandom_range(1, 20);
          ex = near_coord(sx, $urandom_range(0, 1) ? len : -len);
          ey = near_coord(sy, $urandom_range(0, 1) ? len : -len);
        end
        LINE_EMPTY: begin
          ex = sx;
          ey = sy;
        end
        LINE_CORNER: begin
          sx = corner_coord();
          sy = corner_coord();
          ex = corner_coord();
          ey = corner_coord();
        end
        default: ;
      endcase
      send_line(int'(sx), int'(sy), int'(ex), int'(ey));
    end
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x   = '0;
    in_end_y   = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extremes();
    test_empty_lines();
    test_octants();
    test_ties();
    test_random();
    in_valid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
